// ===== rtl/core/echo_delay_offset_averager_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the echo delay and offset averager core.
// Each macro expects signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ECHO_DELAY_OFFSET_AVERAGER_CORE_ASSERT_SVH
`define ECHO_DELAY_OFFSET_AVERAGER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define EDOA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define EDOA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/edoa_pkg.sv =====
// ----------------------------------------------------------------------------
// edoa_pkg
// Shared constants, types and helpers of the echo delay and offset averager.
// ----------------------------------------------------------------------------
package edoa_pkg;

  localparam int WINDOW_SLOTS_DEF = 10;

  localparam int SEC_W    = 32;
  localparam int NS_W     = 30;
  localparam int SAMPLE_W = 48;
  localparam int TIME_W   = 64;
  localparam int PROD_W   = 62;
  localparam int DIV_BITS = 4;

  localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

  typedef enum logic [1:0] {
    MUL_ARRIVAL = 2'd0,
    MUL_SENT    = 2'd1,
    MUL_SERVER  = 2'd2
  } mul_sel_t;

  typedef enum logic {
    RING_DELAY  = 1'b0,
    RING_OFFSET = 1'b1
  } ring_sel_t;

  typedef struct packed {
    logic [SEC_W-1:0] sent_seconds;
    logic [NS_W-1:0]  sent_nanos;
    logic [SEC_W-1:0] server_seconds;
    logic [NS_W-1:0]  server_nanos;
    logic [SEC_W-1:0] arrival_seconds;
    logic [NS_W-1:0]  arrival_nanos;
  } edoa_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_delay_ns;
    logic signed [SAMPLE_W-1:0] mean_offset_ns;
    logic                       delay_window_empty;
    logic                       offset_window_empty;
  } edoa_result_t;

  typedef struct packed {
    logic      capture;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      acc_arrival;
    logic      acc_sent;
    logic      acc_server;
    logic      put_delay;
    logic      put_offset;
    logic      walk_clear;
    logic      walk_step;
    ring_sel_t ring_sel;
    logic      div_load;
    logic      div_step;
    logic      fin_delay;
    logic      load_out;
  } edoa_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
    logic out_free;
  } edoa_stat_t;

  // Clamps a 65-bit signed value to the signed 48-bit range.
  function automatic logic [SAMPLE_W-1:0] sat48(input logic [TIME_W:0] v);
    if (v[TIME_W:SAMPLE_W-1] == {(TIME_W-SAMPLE_W+2){v[TIME_W]}}) begin
      return v[SAMPLE_W-1:0];
    end else if (v[TIME_W]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/core/edoa_if.sv =====
// ----------------------------------------------------------------------------
// edoa_if
// Valid/ready channels for echo reply items and averaged result items.
// ----------------------------------------------------------------------------
interface edoa_in_if;
  logic                          valid;
  logic                          ready;
  logic [edoa_pkg::SEC_W-1:0]    sent_seconds;
  logic [edoa_pkg::NS_W-1:0]     sent_nanos;
  logic [edoa_pkg::SEC_W-1:0]    server_seconds;
  logic [edoa_pkg::NS_W-1:0]     server_nanos;
  logic [edoa_pkg::SEC_W-1:0]    arrival_seconds;
  logic [edoa_pkg::NS_W-1:0]     arrival_nanos;

  modport source (
    output valid, sent_seconds, sent_nanos, server_seconds, server_nanos,
           arrival_seconds, arrival_nanos,
    input  ready
  );
  modport sink (
    input  valid, sent_seconds, sent_nanos, server_seconds, server_nanos,
           arrival_seconds, arrival_nanos,
    output ready
  );
endinterface

interface edoa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [edoa_pkg::SAMPLE_W-1:0] mean_delay_ns;
  logic signed [edoa_pkg::SAMPLE_W-1:0] mean_offset_ns;
  logic                                delay_window_empty;
  logic                                offset_window_empty;

  modport source (
    output valid, mean_delay_ns, mean_offset_ns, delay_window_empty,
           offset_window_empty,
    input  ready
  );
  modport sink (
    input  valid, mean_delay_ns, mean_offset_ns, delay_window_empty,
           offset_window_empty,
    output ready
  );
endinterface

// ===== rtl/core/echo_delay_offset_averager_core.sv =====
// ----------------------------------------------------------------------------
// echo_delay_offset_averager_core
// Round trip delay and clock offset moving averages over echo replies.
//
// Each item on in_ch carries the client send, server and local arrival
// times of one echo reply. For each item the block stores half the round
// trip into a ring of WINDOW_SLOTS delay samples, averages its nonzero
// slots, stores the clock offset into a second ring and averages that.
// One result item per input item appears on out_ch.
// An item passes from acceptance to the result register through the two walks
// over the rings and the two nibble-serial divides. in_ch is ready only
// between items, and the next item is accepted while a result still waits.
// If out_ch stalls, the following result holds the block until taken.
// Reset clears both rings and slot pointers at once and empties out_ch.
// ----------------------------------------------------------------------------
module echo_delay_offset_averager_core #(
  parameter int WINDOW_SLOTS = edoa_pkg::WINDOW_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  edoa_in_if.sink    in_ch,
  edoa_out_if.source out_ch
);

  edoa_pkg::edoa_cmd_t    cmd;
  edoa_pkg::edoa_stat_t   stat;
  edoa_pkg::edoa_item_t   item;
  edoa_pkg::edoa_result_t result;

  assign item.sent_seconds    = in_ch.sent_seconds;
  assign item.sent_nanos      = in_ch.sent_nanos;
  assign item.server_seconds  = in_ch.server_seconds;
  assign item.server_nanos    = in_ch.server_nanos;
  assign item.arrival_seconds = in_ch.arrival_seconds;
  assign item.arrival_nanos   = in_ch.arrival_nanos;

  edoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  edoa_datapath #(
    .WINDOW_SLOTS (WINDOW_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .item      (item),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .result    (result)
  );

  assign out_ch.mean_delay_ns       = result.mean_delay_ns;
  assign out_ch.mean_offset_ns      = result.mean_offset_ns;
  assign out_ch.delay_window_empty  = result.delay_window_empty;
  assign out_ch.offset_window_empty = result.offset_window_empty;

endmodule

// ===== rtl/core/edoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// edoa_ctrl
// Sequencer that steps one echo reply item through the shared datapath.
// ----------------------------------------------------------------------------
module edoa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  edoa_pkg::edoa_stat_t stat,
  output edoa_pkg::edoa_cmd_t  cmd
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_MUL_A  = 15'h0002,
    ST_ACC_A  = 15'h0004,
    ST_ACC_S  = 15'h0008,
    ST_ACC_V  = 15'h0010,
    ST_PUT_D  = 15'h0020,
    ST_WALK_D = 15'h0040,
    ST_DLD_D  = 15'h0080,
    ST_DIV_D  = 15'h0100,
    ST_FIN_D  = 15'h0200,
    ST_PUT_O  = 15'h0400,
    ST_WALK_O = 15'h0800,
    ST_DLD_O  = 15'h1000,
    ST_DIV_O  = 15'h2000,
    ST_DONE   = 15'h4000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = edoa_pkg::MUL_ARRIVAL;
        state_nxt   = ST_ACC_A;
      end
      ST_ACC_A: begin
        cmd.acc_arrival = 1'b1;
        cmd.mul_en      = 1'b1;
        cmd.mul_sel     = edoa_pkg::MUL_SENT;
        state_nxt       = ST_ACC_S;
      end
      ST_ACC_S: begin
        cmd.acc_sent = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = edoa_pkg::MUL_SERVER;
        state_nxt    = ST_ACC_V;
      end
      ST_ACC_V: begin
        cmd.acc_server = 1'b1;
        state_nxt      = ST_PUT_D;
      end
      ST_PUT_D: begin
        cmd.put_delay  = 1'b1;
        cmd.walk_clear = 1'b1;
        state_nxt      = ST_WALK_D;
      end
      ST_WALK_D: begin
        cmd.walk_step = 1'b1;
        cmd.ring_sel  = edoa_pkg::RING_DELAY;
        if (stat.walk_last) begin
          state_nxt = ST_DLD_D;
        end
      end
      ST_DLD_D: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV_D;
      end
      ST_DIV_D: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_FIN_D;
        end
      end
      ST_FIN_D: begin
        cmd.fin_delay = 1'b1;
        state_nxt     = ST_PUT_O;
      end
      ST_PUT_O: begin
        cmd.put_offset = 1'b1;
        cmd.walk_clear = 1'b1;
        state_nxt      = ST_WALK_O;
      end
      ST_WALK_O: begin
        cmd.walk_step = 1'b1;
        cmd.ring_sel  = edoa_pkg::RING_OFFSET;
        if (stat.walk_last) begin
          state_nxt = ST_DLD_O;
        end
      end
      ST_DLD_O: begin
        cmd.div_load = 1'b1;
        state_nxt    = ST_DIV_O;
      end
      ST_DIV_O: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/edoa_datapath.sv =====
// ----------------------------------------------------------------------------
// edoa_datapath
// Timestamp multiplier, sample rings, window accumulator, serial divider
// and result register of the echo delay and offset averager.
// ----------------------------------------------------------------------------
`include "echo_delay_offset_averager_core_assert.svh"

module edoa_datapath #(
  parameter int WINDOW_SLOTS = edoa_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  edoa_pkg::edoa_cmd_t    cmd,
  output edoa_pkg::edoa_stat_t   stat,
  input  edoa_pkg::edoa_item_t   item,
  input  logic                   out_ready,
  output logic                   out_valid,
  output edoa_pkg::edoa_result_t result
);

  localparam int SW    = edoa_pkg::SAMPLE_W;
  localparam int TW    = edoa_pkg::TIME_W;
  localparam int PW    = edoa_pkg::PROD_W;
  localparam int NW    = edoa_pkg::NS_W;
  localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
  localparam int SUM_W = SW + CNT_W;
  localparam int QW    = ((SUM_W + edoa_pkg::DIV_BITS - 1) / edoa_pkg::DIV_BITS)
                         * edoa_pkg::DIV_BITS;
  localparam int STEPS = QW / edoa_pkg::DIV_BITS;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_SLOTS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_SLOTS);

  edoa_pkg::edoa_item_t item_r;

  logic [edoa_pkg::SEC_W-1:0] sec_sel;
  logic [PW-1:0]              prod_nxt;
  logic [PW-1:0]              prod_r;
  logic [TW-1:0]              arr_r;
  logic [TW-1:0]              diff_r;
  logic [TW-1:0]              srv_r;

  logic [SW-1:0]    dring_r [WINDOW_SLOTS];
  logic [SW-1:0]    oring_r [WINDOW_SLOTS];
  logic [IDX_W-1:0] d_slot_r;
  logic [IDX_W-1:0] o_slot_r;

  logic [TW:0]   half_sum;
  logic [TW:0]   half_ext;
  logic [SW-1:0] delay_sat;
  logic [TW:0]   off_ext;
  logic [SW-1:0] offset_sat;

  logic [IDX_W-1:0] idx_r;
  logic [SW-1:0]    rd_sample;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;

  logic [SUM_W-1:0]  sum_mag;
  logic [QW-1:0]     q_r;
  logic [QW-1:0]     q_nxt;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic [SW-1:0]     div_res;
  logic              win_empty;

  logic [SW-1:0]          mean_d_r;
  logic                   d_empty_r;
  edoa_pkg::edoa_result_t res_r;
  logic                   out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      edoa_pkg::MUL_ARRIVAL: sec_sel = item_r.arrival_seconds;
      edoa_pkg::MUL_SENT:    sec_sel = item_r.sent_seconds;
      edoa_pkg::MUL_SERVER:  sec_sel = item_r.server_seconds;
      default:               sec_sel = '0;
    endcase
  end

  assign prod_nxt = {{(PW-edoa_pkg::SEC_W){1'b0}}, sec_sel}
                    * {{(PW-NW){1'b0}}, edoa_pkg::NS_PER_SEC};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_arrival) begin
      arr_r <= {{(TW-PW){1'b0}}, prod_r} + {{(TW-NW){1'b0}}, item_r.arrival_nanos};
    end
    if (cmd.acc_sent) begin
      diff_r <= arr_r - ({{(TW-PW){1'b0}}, prod_r}
                         + {{(TW-NW){1'b0}}, item_r.sent_nanos});
    end
    if (cmd.acc_server) begin
      srv_r <= arr_r - ({{(TW-PW){1'b0}}, prod_r}
                        + {{(TW-NW){1'b0}}, item_r.server_nanos});
    end
  end

  // Halving rounds toward zero, so a negative difference gets one added first.
  assign half_sum   = {diff_r[TW-1], diff_r} + {{TW{1'b0}}, diff_r[TW-1]};
  assign half_ext   = {half_sum[TW], half_sum[TW:1]};
  assign delay_sat  = edoa_pkg::sat48(half_ext);
  assign off_ext    = {srv_r[TW-1], srv_r} - {{(TW+1-SW){mean_d_r[SW-1]}}, mean_d_r};
  assign offset_sat = edoa_pkg::sat48(off_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        dring_r[i] <= '0;
        oring_r[i] <= '0;
      end
      d_slot_r <= '0;
      o_slot_r <= '0;
    end else begin
      if (cmd.put_delay) begin
        dring_r[d_slot_r] <= delay_sat;
        d_slot_r          <= (d_slot_r == LAST_IDX) ? '0 : d_slot_r + 1'b1;
      end
      if (cmd.put_offset) begin
        oring_r[o_slot_r] <= offset_sat;
        o_slot_r          <= (o_slot_r == LAST_IDX) ? '0 : o_slot_r + 1'b1;
      end
    end
  end

  assign rd_sample = (cmd.ring_sel == edoa_pkg::RING_OFFSET) ? oring_r[idx_r]
                                                              : dring_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else if (cmd.walk_clear) begin
      idx_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else if (cmd.walk_step) begin
      idx_r <= idx_r + 1'b1;
      if (rd_sample != '0) begin
        sum_r <= sum_r + {{CNT_W{rd_sample[SW-1]}}, rd_sample};
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign sum_mag = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;

  // Restoring division of the sum magnitude by the sample count, a nibble a cycle.
  always_comb begin : div_stage
    logic [CNT_W:0] trial;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < edoa_pkg::DIV_BITS; k++) begin
      trial = {rem_nxt, q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (trial >= {1'b0, cnt_r}) begin
        rem_nxt  = CNT_W'(trial - {1'b0, cnt_r});
        q_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      q_r    <= QW'(sum_mag);
      rem_r  <= '0;
      neg_r  <= sum_r[SUM_W-1];
      step_r <= '0;
    end else if (cmd.div_step) begin
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign win_empty = (cnt_r == '0);
  assign div_res   = neg_r ? (~q_r[SW-1:0] + 1'b1) : q_r[SW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.fin_delay) begin
      mean_d_r  <= win_empty ? '0 : div_res;
      d_empty_r <= win_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_r.mean_delay_ns       <= mean_d_r;
      res_r.mean_offset_ns      <= win_empty ? '0 : div_res;
      res_r.delay_window_empty  <= d_empty_r;
      res_r.offset_window_empty <= win_empty;
    end
  end

  assign out_valid      = out_valid_r;
  assign result         = res_r;
  assign stat.walk_last = (idx_r == LAST_IDX);
  assign stat.div_last  = (step_r == LAST_STEP);
  assign stat.out_free  = !out_valid_r || out_ready;

  `EDOA_ASSERT_ALWAYS(a_slot_range, (d_slot_r <= LAST_IDX) && (o_slot_r <= LAST_IDX),
                      "slot pointer beyond window")
  `EDOA_ASSERT_ALWAYS(a_count_range, cnt_r <= FULL_CNT, "sample count beyond window")
  `EDOA_ASSERT_IMPLY(a_load_free, cmd.load_out, !out_valid_r || out_ready,
                     "result overwritten before taken")
  `EDOA_ASSERT_IMPLY(a_mean_range, cmd.fin_delay && !win_empty,
                     q_r <= (QW'(1) << (SW - 1)), "delay mean out of range")

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the echo delay and clock offset averager core. Each accepted
// echo reply item updates a predictor that keeps its own delay and offset
// windows, and the expected averages and empty flags are queued. Every
// result item is compared field by field with the oldest queued entry.
// Stimulus runs from directed corner items through random, mostly realistic
// echo replies, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int SEC_W = edoa_pkg::SEC_W;
  localparam int NS_W = edoa_pkg::NS_W;
  localparam int SAMPLE_W = edoa_pkg::SAMPLE_W;
  localparam int SLOTS = edoa_pkg::WINDOW_SLOTS_DEF;
  localparam longint NS_PER_S = 64'sd1000000000;
  localparam longint SAMPLE_MAX = 64'sd140737488355327;
  localparam longint SAMPLE_MIN = -64'sd140737488355328;
  localparam int DRAIN_CYCLES = 10 + 2 * SLOTS + 2 * 13 + 40;
  localparam logic [SEC_W-1:0] SEC_ALL = '1;
  localparam logic [NS_W-1:0] NS_ALL = '1;

  logic clk;
  logic rst_n;

  edoa_in_if in_ch ();
  edoa_out_if out_ch ();

  echo_delay_offset_averager_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  longint delay_window[SLOTS] = '{default: 0};
  longint offset_window[SLOTS] = '{default: 0};
  int delay_wr = 0;
  int offset_wr = 0;
  edoa_pkg::edoa_result_t pending_averages[$];
  int mismatches = 0;
  int hold_cycles = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint stamp_ns(logic [SEC_W-1:0] sec, logic [NS_W-1:0] nanos);
    longint s;
    longint n;
    s = longint'(sec);
    n = longint'(nanos);
    return s * NS_PER_S + n;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  function automatic longint window_mean(input longint win[SLOTS], output bit empty);
    longint sum;
    longint cnt;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (win[i] != 0) begin
        sum += win[i];
        cnt++;
      end
    end
    empty = (cnt == 0);
    return empty ? 64'sd0 : sum / cnt;
  endfunction

  function automatic edoa_pkg::edoa_result_t predict_averages(edoa_pkg::edoa_item_t it);
    longint sent;
    longint server;
    longint arrival;
    longint delay;
    longint offset;
    longint mean_d;
    longint mean_o;
    bit d_empty;
    bit o_empty;
    edoa_pkg::edoa_result_t r;
    sent = stamp_ns(it.sent_seconds, it.sent_nanos);
    server = stamp_ns(it.server_seconds, it.server_nanos);
    arrival = stamp_ns(it.arrival_seconds, it.arrival_nanos);
    delay = clamp48((arrival - sent) / 2);
    delay_window[delay_wr] = delay;
    delay_wr = (delay_wr == SLOTS - 1) ? 0 : delay_wr + 1;
    mean_d = window_mean(delay_window, d_empty);
    offset = clamp48((arrival - server) - mean_d);
    offset_window[offset_wr] = offset;
    offset_wr = (offset_wr == SLOTS - 1) ? 0 : offset_wr + 1;
    mean_o = window_mean(offset_window, o_empty);
    r.mean_delay_ns = mean_d[SAMPLE_W-1:0];
    r.mean_offset_ns = mean_o[SAMPLE_W-1:0];
    r.delay_window_empty = d_empty;
    r.offset_window_empty = o_empty;
    return r;
  endfunction

  function automatic edoa_pkg::edoa_item_t echo_item(
      logic [SEC_W-1:0] ss, logic [NS_W-1:0] sn,
      logic [SEC_W-1:0] vs, logic [NS_W-1:0] vn,
      logic [SEC_W-1:0] as, logic [NS_W-1:0] an);
    edoa_pkg::edoa_item_t it;
    it.sent_seconds = ss;
    it.sent_nanos = sn;
    it.server_seconds = vs;
    it.server_nanos = vn;
    it.arrival_seconds = as;
    it.arrival_nanos = an;
    return it;
  endfunction

  function automatic logic [NS_W-1:0] nanos_of(int v);
    return NS_W'(v);
  endfunction

  function automatic logic [SEC_W+NS_W-1:0] split_ns(longint t);
    logic [SEC_W-1:0] s;
    logic [NS_W-1:0] n;
    s = SEC_W'(t / NS_PER_S);
    n = NS_W'(t % NS_PER_S);
    return {s, n};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 80);
  endfunction

  task automatic send_item(edoa_pkg::edoa_item_t it);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sent_seconds <= it.sent_seconds;
    in_ch.sent_nanos <= it.sent_nanos;
    in_ch.server_seconds <= it.server_seconds;
    in_ch.server_nanos <= it.server_nanos;
    in_ch.arrival_seconds <= it.arrival_seconds;
    in_ch.arrival_nanos <= it.arrival_nanos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_averages.push_back(predict_averages(it));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic signed [SAMPLE_W-1:0] expv,
                             logic signed [SAMPLE_W-1:0] actv);
    if (actv !== expv) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
    end
  endtask

  task automatic check_result();
    edoa_pkg::edoa_result_t exp_r;
    if (pending_averages.size() == 0) begin
      mismatches++;
      $display("%0t: result item with none expected, expected nothing, actual delay %0d",
               $time, out_ch.mean_delay_ns);
      return;
    end
    exp_r = pending_averages.pop_front();
    check_field("mean_delay_ns", exp_r.mean_delay_ns, out_ch.mean_delay_ns);
    check_field("mean_offset_ns", exp_r.mean_offset_ns, out_ch.mean_offset_ns);
    check_field("delay_window_empty", SAMPLE_W'(exp_r.delay_window_empty),
                SAMPLE_W'(out_ch.delay_window_empty));
    check_field("offset_window_empty", SAMPLE_W'(exp_r.offset_window_empty),
                SAMPLE_W'(out_ch.offset_window_empty));
  endtask

  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result();
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic test_directed_corners();
    send_item(echo_item(0, 0, 0, 0, 0, 0));
    send_item(echo_item(0, 0, 0, 5, 0, 0));
    send_item(echo_item(0, 0, 0, 0, 0, 3));
    send_item(echo_item(0, 7, 0, 0, 0, 0));
    send_item(echo_item(SEC_ALL, NS_ALL, SEC_ALL, NS_ALL, SEC_ALL, NS_ALL));
    send_item(echo_item(0, 0, 0, 0, SEC_ALL, NS_ALL));
    send_item(echo_item(SEC_ALL, NS_ALL, SEC_ALL, NS_ALL, 0, 0));
    send_item(echo_item(5, NS_ALL, 6, 0, 6, NS_ALL));
    send_item(echo_item(0, 0, SEC_ALL, NS_ALL, 0, 0));
    send_item(echo_item(32'hAAAA_AAAA, 30'h1555_5555, 32'h5555_5555, 30'h2AAA_AAAA,
                        32'hAAAA_AAAA, 30'h2AAA_AAAA));
    send_item(echo_item(32'h5555_5555, 30'h2AAA_AAAA, 32'hAAAA_AAAA, 30'h1555_5555,
                        32'h5555_5555, 30'h1555_5555));
    for (int i = 0; i < 11; i++) begin
      send_item(echo_item(100 + i, 0, 100 + i, nanos_of(500 + 7 * i),
                          100 + i, nanos_of(1000 + 3 * i)));
    end
  endtask

  // Identical timestamps give zero samples, so both windows drain back to empty.
  task automatic test_empty_window_return();
    logic [SEC_W-1:0] s;
    logic [NS_W-1:0] n;
    for (int i = 0; i < 24; i++) begin
      s = $urandom;
      n = NS_W'($urandom);
      send_item(echo_item(s, n, s, n, s, n));
    end
  endtask

  task automatic test_random_mix(int count);
    edoa_pkg::edoa_item_t it;
    longint sent_t;
    longint rtt;
    longint skew;
    int kind;
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 119) wait_drained();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        it = echo_item($urandom, nanos_of($urandom), $urandom, nanos_of($urandom),
                       $urandom, nanos_of($urandom));
      end else begin
        sent_t = longint'($urandom_range(10, 32'hFFFF_0000)) * NS_PER_S
               + longint'($urandom_range(0, 999_999_999));
        if ($urandom_range(0, 9) == 0) rtt = longint'($urandom) * 1000;
        else rtt = longint'($urandom_range(0, 2_000_000));
        if (kind >= 85) rtt = longint'($urandom_range(0, 1));
        skew = longint'($urandom_range(0, 1_000_000_000)) - 500_000_000;
        {it.sent_seconds, it.sent_nanos} = split_ns(sent_t);
        {it.server_seconds, it.server_nanos} = split_ns(sent_t + rtt / 2 + skew);
        {it.arrival_seconds, it.arrival_nanos} = split_ns(sent_t + rtt);
      end
      send_item(it);
    end
  endtask

  // The receiver holds off long enough for the core to fill and stall its input.
  task automatic test_output_backpressure();
    tx_gaps_on = 1'b0;
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      send_item(echo_item(200 + i, 0, 200 + i, nanos_of(40_000 + i),
                          200 + i, nanos_of(90_000 + 11 * i)));
    end
    tx_gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_quiet_stretch();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    test_random_mix(40);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sent_seconds <= '0;
    in_ch.sent_nanos <= '0;
    in_ch.server_seconds <= '0;
    in_ch.server_nanos <= '0;
    in_ch.arrival_seconds <= '0;
    in_ch.arrival_nanos <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_empty_window_return();
    test_output_backpressure();
    test_quiet_stretch();
    test_random_mix(500);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/edoa_pkg.sv
rtl/core/edoa_if.sv
rtl/core/edoa_ctrl.sv
rtl/core/edoa_datapath.sv
rtl/core/echo_delay_offset_averager_core.sv
dv/tb.sv
